// ===== rtl/rvd_pkg.sv =====
// rvd_pkg: shared types and encodings for the RV32IM instruction decoder.
// Holds format and mnemonic codes, opcode/funct constants and the decode record.
// No dependencies.
package rvd_pkg;

    typedef enum logic [2:0] {
        FMT_NONE = 3'd0,
        FMT_R    = 3'd1,
        FMT_I    = 3'd2,
        FMT_S    = 3'd3,
        FMT_B    = 3'd4,
        FMT_U    = 3'd5,
        FMT_J    = 3'd6
    } format_t;

    typedef enum logic [5:0] {
        MN_NONE   = 6'd0,
        MN_SLLI   = 6'd1,
        MN_SRLI   = 6'd2,
        MN_SRAI   = 6'd3,
        MN_ADD    = 6'd4,
        MN_SUB    = 6'd5,
        MN_SLL    = 6'd6,
        MN_SLT    = 6'd7,
        MN_SLTU   = 6'd8,
        MN_XOR    = 6'd9,
        MN_SRL    = 6'd10,
        MN_SRA    = 6'd11,
        MN_OR     = 6'd12,
        MN_AND    = 6'd13,
        MN_MUL    = 6'd14,
        MN_MULH   = 6'd15,
        MN_MULHSU = 6'd16,
        MN_MULHU  = 6'd17,
        MN_DIV    = 6'd18,
        MN_DIVU   = 6'd19,
        MN_REM    = 6'd20,
        MN_REMU   = 6'd21,
        MN_FENCE  = 6'd22,
        MN_ECALL  = 6'd23,
        MN_EBREAK = 6'd24,
        MN_JALR   = 6'd25,
        MN_LB     = 6'd26,
        MN_LH     = 6'd27,
        MN_LW     = 6'd28,
        MN_LBU    = 6'd29,
        MN_LHU    = 6'd30,
        MN_ADDI   = 6'd31,
        MN_SLTI   = 6'd32,
        MN_SLTIU  = 6'd33,
        MN_XORI   = 6'd34,
        MN_ORI    = 6'd35,
        MN_ANDI   = 6'd36,
        MN_SB     = 6'd37,
        MN_SH     = 6'd38,
        MN_SW     = 6'd39,
        MN_BEQ    = 6'd40,
        MN_BNE    = 6'd41,
        MN_BLT    = 6'd42,
        MN_BGE    = 6'd43,
        MN_BLTU   = 6'd44,
        MN_BGEU   = 6'd45,
        MN_LUI    = 6'd46,
        MN_AUIPC  = 6'd47,
        MN_JAL    = 6'd48
    } mnemonic_t;

    // opcode bits 1..0 of every 32-bit encoding
    localparam logic [1:0] OPC_LOW = 2'b11;

    // opcode bits 6..2
    localparam logic [4:0] OPC_LOAD     = 5'h00;
    localparam logic [4:0] OPC_MISC_MEM = 5'h03;
    localparam logic [4:0] OPC_OP_IMM   = 5'h04;
    localparam logic [4:0] OPC_AUIPC    = 5'h05;
    localparam logic [4:0] OPC_STORE    = 5'h08;
    localparam logic [4:0] OPC_OP       = 5'h0C;
    localparam logic [4:0] OPC_LUI      = 5'h0D;
    localparam logic [4:0] OPC_BRANCH   = 5'h18;
    localparam logic [4:0] OPC_JALR     = 5'h19;
    localparam logic [4:0] OPC_JAL      = 5'h1B;
    localparam logic [4:0] OPC_SYSTEM   = 5'h1C;

    localparam logic [2:0] F3_ZERO = 3'b000;
    localparam logic [2:0] F3_SLL  = 3'b001;
    localparam logic [2:0] F3_SR   = 3'b101;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_MEXT = 7'h01;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // instruction bits 31..7 for the two SYSTEM words recognized
    localparam logic [24:0] SYS_ECALL  = 25'h0000000;
    localparam logic [24:0] SYS_EBREAK = 25'h0002000;

    typedef struct packed {
        format_t   fmt;
        mnemonic_t mn;
        logic      shamt_form;  // OP-IMM shift: immediate is the shift amount
    } decode_t;

endpackage

// ===== rtl/rvd_classify.sv =====
// rvd_classify: maps an instruction word to its format and mnemonic code.
// Pure combinational; depends on rvd_pkg.
module rvd_classify
    import rvd_pkg::*;
(
    input  logic [31:0] word,
    output decode_t     dec
);

    localparam mnemonic_t ALU_BASE [8] = '{MN_ADD, MN_SLL, MN_SLT, MN_SLTU,
                                           MN_XOR, MN_SRL, MN_OR, MN_AND};
    localparam mnemonic_t ALU_MEXT [8] = '{MN_MUL, MN_MULH, MN_MULHSU, MN_MULHU,
                                           MN_DIV, MN_DIVU, MN_REM, MN_REMU};
    localparam mnemonic_t LOAD_TAB [8] = '{MN_LB, MN_LH, MN_LW, MN_NONE,
                                           MN_LBU, MN_LHU, MN_NONE, MN_NONE};
    localparam mnemonic_t ALUI_TAB [8] = '{MN_ADDI, MN_NONE, MN_SLTI, MN_SLTIU,
                                           MN_XORI, MN_NONE, MN_ORI, MN_ANDI};
    localparam mnemonic_t STORE_TAB [8] = '{MN_SB, MN_SH, MN_SW, MN_NONE,
                                            MN_NONE, MN_NONE, MN_NONE, MN_NONE};
    localparam mnemonic_t BR_TAB [8] = '{MN_BEQ, MN_BNE, MN_NONE, MN_NONE,
                                         MN_BLT, MN_BGE, MN_BLTU, MN_BGEU};

    logic [2:0] f3;
    logic [6:0] f7;
    format_t    fmt;
    mnemonic_t  mn;
    logic       shamt_form;

    assign f3 = word[14:12];
    assign f7 = word[31:25];

    always_comb
    begin
        fmt        = FMT_NONE;
        mn         = MN_NONE;
        shamt_form = 1'b0;
        if (word[1:0] == OPC_LOW)
        begin
            unique case (word[6:2])
                OPC_LOAD:
                begin
                    fmt = FMT_I;
                    mn  = LOAD_TAB[f3];
                end
                OPC_MISC_MEM:
                begin
                    fmt = FMT_I;
                    mn  = (f3 == F3_ZERO) ? MN_FENCE : MN_NONE;
                end
                OPC_OP_IMM:
                begin
                    if (f3 == F3_SLL || f3 == F3_SR)
                    begin
                        fmt        = FMT_R;
                        shamt_form = 1'b1;
                        if (f7 == F7_BASE)
                            mn = (f3 == F3_SLL) ? MN_SLLI : MN_SRLI;
                        else if (f7 == F7_ALT && f3 == F3_SR)
                            mn = MN_SRAI;
                    end
                    else
                    begin
                        fmt = FMT_I;
                        mn  = ALUI_TAB[f3];
                    end
                end
                OPC_AUIPC:
                begin
                    fmt = FMT_U;
                    mn  = MN_AUIPC;
                end
                OPC_STORE:
                begin
                    fmt = FMT_S;
                    mn  = STORE_TAB[f3];
                end
                OPC_OP:
                begin
                    fmt = FMT_R;
                    if (f7 == F7_BASE)
                        mn = ALU_BASE[f3];
                    else if (f7 == F7_MEXT)
                        mn = ALU_MEXT[f3];
                    else if (f7 == F7_ALT && f3 == F3_ZERO)
                        mn = MN_SUB;
                    else if (f7 == F7_ALT && f3 == F3_SR)
                        mn = MN_SRA;
                end
                OPC_LUI:
                begin
                    fmt = FMT_U;
                    mn  = MN_LUI;
                end
                OPC_BRANCH:
                begin
                    fmt = FMT_B;
                    mn  = BR_TAB[f3];
                end
                OPC_JALR:
                begin
                    fmt = FMT_I;
                    mn  = (f3 == F3_ZERO) ? MN_JALR : MN_NONE;
                end
                OPC_JAL:
                begin
                    fmt = FMT_J;
                    mn  = MN_JAL;
                end
                OPC_SYSTEM:
                begin
                    fmt = FMT_I;
                    if (word[31:7] == SYS_ECALL)
                        mn = MN_ECALL;
                    else if (word[31:7] == SYS_EBREAK)
                        mn = MN_EBREAK;
                end
                default:
                begin
                    fmt = FMT_NONE;
                    mn  = MN_NONE;
                end
            endcase
        end
        // unrecognized words carry no format
        if (mn == MN_NONE)
            fmt = FMT_NONE;
    end

    assign dec.fmt        = fmt;
    assign dec.mn         = mn;
    assign dec.shamt_form = shamt_form;

endmodule

// ===== rtl/rvd_imm_gen.sv =====
// rvd_imm_gen: builds the immediate for the decoded format; sign-extended, but a shift amount is zero-extended.
// Pure combinational; depends on rvd_pkg.
module rvd_imm_gen
    import rvd_pkg::*;
(
    input  logic [31:0]        word,
    input  decode_t            dec,
    output logic signed [31:0] imm
);

    always_comb
    begin
        unique case (dec.fmt)
            FMT_R:
                imm = dec.shamt_form ? {27'b0, word[24:20]} : 32'sd0;
            FMT_I:
                imm = {{20{word[31]}}, word[31:20]};
            FMT_S:
                imm = {{20{word[31]}}, word[31:25], word[11:7]};
            FMT_B:
                imm = {{19{word[31]}}, word[31], word[7], word[30:25],
                       word[11:8], 1'b0};
            FMT_U:
                imm = {word[31:12], 12'b0};
            FMT_J:
                imm = {{11{word[31]}}, word[31], word[19:12], word[20],
                       word[30:21], 1'b0};
            default:
                imm = 32'sd0;
        endcase
    end

endmodule

// ===== rtl/rv32im_instruction_decoder.sv =====
// rv32im_instruction_decoder: top level, input register, decode logic, result register.
// Depends on rvd_pkg, rvd_classify and rvd_imm_gen.
//
// Usage:
//   Drive instruction_word and pulse start. An item is taken at each rising
//   edge where start is high and busy is low; busy is never raised, so an
//   item may be presented on every cycle.
//   The word is captured in an input register, decoded by one level of
//   combinational logic and captured in the result register. The result
//   shows on the output ports with done high for exactly one cycle, once
//   the item has passed the input register and the result register.
//   Throughput: 1 item per cycle, since busy is never raised; the path
//   from the input register through the opcode/funct compare and
//   immediate mux sets the clock period.
//   The receiver cannot stall: each result is presented once and must be
//   taken in that cycle.
//   Reset (rst_n low, asynchronous) drops any items in flight and clears done;
//   result payload holds stale data until the next item comes out.
module rv32im_instruction_decoder
    import rvd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        instruction_word,
    output logic               done,
    output logic [2:0]         instr_format,
    output logic [5:0]         mnemonic,
    output logic [6:0]         major_opcode,
    output logic [2:0]         funct_three,
    output logic [6:0]         funct_seven,
    output logic [4:0]         dest_reg,
    output logic [4:0]         src_reg_one,
    output logic [4:0]         src_reg_two,
    output logic signed [31:0] immediate
);

    logic               in_valid_reg;
    logic [31:0]        word_reg;
    logic               done_reg;
    format_t            fmt_reg;
    mnemonic_t          mn_reg;
    logic [31:0]        res_word_reg;
    logic signed [31:0] imm_reg;

    decode_t            dec;
    logic signed [31:0] imm_next;

    assign busy = 1'b0;

    rvd_classify u_classify (
        .word (word_reg),
        .dec  (dec)
    );

    rvd_imm_gen u_imm_gen (
        .word (word_reg),
        .dec  (dec),
        .imm  (imm_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
            done_reg     <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            word_reg <= instruction_word;
        if (in_valid_reg)
        begin
            fmt_reg      <= dec.fmt;
            mn_reg       <= dec.mn;
            res_word_reg <= word_reg;
            imm_reg      <= imm_next;
        end
    end

    assign done         = done_reg;
    assign instr_format = fmt_reg;
    assign mnemonic     = mn_reg;
    assign major_opcode = res_word_reg[6:0];
    assign funct_three  = res_word_reg[14:12];
    assign funct_seven  = res_word_reg[31:25];
    assign dest_reg     = res_word_reg[11:7];
    assign src_reg_one  = res_word_reg[19:15];
    assign src_reg_two  = res_word_reg[24:20];
    assign immediate    = imm_reg;

    // every accepted item comes out through the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##2 done)
        else $error("decoded item missing two cycles after accept");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result strobe without an accepted item");

    a_unknown_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && mnemonic == MN_NONE |-> instr_format == FMT_NONE && immediate == 32'sd0)
        else $error("unknown encoding carries format or immediate");

    a_low_bits: assert property (@(posedge clk) disable iff (!rst_n)
        done && mnemonic != MN_NONE |-> major_opcode[1:0] == OPC_LOW)
        else $error("mnemonic given for a non-32-bit encoding");

    a_upper_imm: assert property (@(posedge clk) disable iff (!rst_n)
        done && instr_format == FMT_U |-> immediate[11:0] == 12'b0)
        else $error("upper immediate has low bits set");

endmodule
